FILE: rtl/acrt_pkg.sv
// ----------------------------------------------------------------------------
// acrt_pkg: shared types and constants for the adaptive chunk rate throttle
// Widths, register codes, reset values and the register file bundle.
// ----------------------------------------------------------------------------
package acrt_pkg;

    localparam int CW        = 48;              // count / time / wait width
    localparam int CHUNK_W   = 31;              // chunk size width
    localparam int RATE_W    = 32;              // rate and threshold width
    localparam int SUM_W     = CW + 1;          // total + chunk
    localparam int USEC_W    = 20;              // width of one million
    localparam int NUM_W     = SUM_W + USEC_W;  // scaled dividend and quotient
    localparam int CNT_W     = $clog2(NUM_W);   // divide step counter
    localparam int DIFF_W    = NUM_W + 1;       // signed quotient minus elapsed
    localparam int IDX_W     = 3;               // register index width

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_RATE_LIMIT = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOW_WAIT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_HIGH_WAIT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SMALLEST   = 3'd3;
    localparam logic [IDX_W-1:0] REG_LARGEST    = 3'd4;
    localparam logic [IDX_W-1:0] REG_NORMAL     = 3'd5;

    // Reset values
    localparam logic [RATE_W-1:0]  RST_RATE_LIMIT = 32'd0;
    localparam logic [RATE_W-1:0]  RST_LOW_WAIT   = 32'd10000;
    localparam logic [RATE_W-1:0]  RST_HIGH_WAIT  = 32'd2000000;
    localparam logic [CHUNK_W-1:0] RST_SMALLEST   = 31'd4096;
    localparam logic [CHUNK_W-1:0] RST_LARGEST    = 31'd1048576;
    localparam logic [CHUNK_W-1:0] RST_NORMAL     = 31'd65536;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_limit;
        logic [RATE_W-1:0]  low_wait;
        logic [RATE_W-1:0]  high_wait;
        logic [CHUNK_W-1:0] smallest;
        logic [CHUNK_W-1:0] largest;
        logic [CHUNK_W-1:0] normal;
    } t_cfg;

endpackage

FILE: rtl/acrt_cfg_regs.sv
// ----------------------------------------------------------------------------
// acrt_cfg_regs: configuration register file
// Takes indexed writes and presents all registers as one bundle.
// ----------------------------------------------------------------------------
module acrt_cfg_regs
    import acrt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [RATE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_limit <= RST_RATE_LIMIT;
            r_cfg.low_wait   <= RST_LOW_WAIT;
            r_cfg.high_wait  <= RST_HIGH_WAIT;
            r_cfg.smallest   <= RST_SMALLEST;
            r_cfg.largest    <= RST_LARGEST;
            r_cfg.normal     <= RST_NORMAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RATE_LIMIT: r_cfg.rate_limit <= i_cfg_data;
                REG_LOW_WAIT:   r_cfg.low_wait   <= i_cfg_data;
                REG_HIGH_WAIT:  r_cfg.high_wait  <= i_cfg_data;
                REG_SMALLEST:   r_cfg.smallest   <= i_cfg_data[CHUNK_W-1:0];
                REG_LARGEST:    r_cfg.largest    <= i_cfg_data[CHUNK_W-1:0];
                REG_NORMAL:     r_cfg.normal     <= i_cfg_data[CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/acrt_divider.sv
// ----------------------------------------------------------------------------
// acrt_divider: shared radix-2 restoring divider
// Scales the byte sum by one million on start, then retires one quotient
// bit per cycle against the rate.
// ----------------------------------------------------------------------------
module acrt_divider
    import acrt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SUM_W-1:0]   i_sum,
    input  logic [RATE_W-1:0]  i_divisor,
    output logic               o_done,
    output logic [NUM_W-1:0]   o_quot
);

    logic [NUM_W-1:0]  r_num;   // dividend bits out at top, quotient bits in at bottom
    logic [RATE_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [RATE_W:0]   n_trial;
    logic              n_ge;
    logic [RATE_W:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_num[NUM_W-1]};
        n_ge    = (n_trial >= {1'b0, i_divisor});
        n_diff  = n_trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUM_W'(i_sum) * NUM_W'(USEC_PER_SEC);
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], n_ge};
            r_rem <= n_ge ? n_diff[RATE_W-1:0] : n_trial[RATE_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running divide");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

endmodule

FILE: rtl/adaptive_chunk_rate_throttle.sv
// ----------------------------------------------------------------------------
// adaptive_chunk_rate_throttle: byte-rate throttle with adaptive chunk size
// Flow: with throttling off (rate zero or no bytes moved) a transaction goes
//   straight to the output state; otherwise it passes sum, divide, diff and
//   decide, repeated once when the wait is recomputed after a chunk update.
// The next transaction is taken only after the result is loaded, which output
//   stalls hold off; a 69-step bit-serial divide gives (total + chunk) * 1e6 / rate.
// Reset (synchronous, active low) restores register defaults and the chunk.
// ----------------------------------------------------------------------------
module adaptive_chunk_rate_throttle
    import acrt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [4*CW-1:0]     i_s_tdata,   // step_bytes, sent_total, now_us, start_us
    // result stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [CW-1:0]       o_m_tdata,   // wait_us (signed)
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [RATE_W-1:0]   i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DIFF,
        S_DECIDE,
        S_OUT
    } t_state;

    t_cfg cfg;

    t_state             r_state;
    logic [CW-1:0]      r_total;
    logic [CW-1:0]      r_elapsed;
    logic [CHUNK_W-1:0] r_chunk;
    logic [SUM_W-1:0]   r_sum;
    logic               r_start;
    logic               r_pass;      // second computation already done
    logic               r_neg;
    logic [NUM_W-1:0]   r_mag;
    logic               r_m_valid;
    logic [CW-1:0]      r_m_data;

    logic               div_done;
    logic [NUM_W-1:0]   div_quot;

    logic [CW-1:0]      in_step;
    logic [CW-1:0]      in_total;
    logic [CW-1:0]      in_now;
    logic [CW-1:0]      in_start;
    logic [CW-1:0]      n_now;
    logic               s_accept;
    logic               m_load;
    logic [DIFF_W-1:0]  n_diff;
    logic [DIFF_W-1:0]  n_neg_diff;
    logic               n_grow;
    logic               n_shrink;
    logic [CHUNK_W:0]   n_avg_sum;
    logic [CHUNK_W-1:0] n_next;
    logic [CW-1:0]      n_wait;
    logic [CW-1:0]      n_neg_wait;

    localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] NEG_MIN = {1'b1, {(CW-1){1'b0}}};

    acrt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    acrt_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_sum     (r_sum),
        .i_divisor (cfg.rate_limit),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    assign in_step  = i_s_tdata[CW-1:0];
    assign in_total = i_s_tdata[2*CW-1:CW];
    assign in_now   = i_s_tdata[3*CW-1:2*CW];
    assign in_start = i_s_tdata[4*CW-1:3*CW];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    // load the result register once it is empty or being drained
    assign m_load     = (r_state == S_OUT) && (!r_m_valid || i_m_tready);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    always_comb begin
        // a missing clock or one behind the start counts as no time elapsed
        n_now = ((in_now == '0) || (in_start > in_now)) ? in_start : in_now;

        // signed wait = quotient - elapsed, kept as sign and magnitude
        n_diff     = {1'b0, div_quot} - DIFF_W'(r_elapsed);
        n_neg_diff = '0 - n_diff;

        // chunk adaptation from the exact, unsaturated wait
        n_grow    = r_neg || (r_mag < NUM_W'(cfg.low_wait));
        n_shrink  = !r_neg && (r_mag > NUM_W'(cfg.high_wait));
        if (n_grow) begin
            n_avg_sum = {1'b0, cfg.largest} + {1'b0, r_chunk};
        end else begin
            n_avg_sum = {1'b0, cfg.smallest} + {1'b0, r_chunk};
        end
        if (n_grow || n_shrink) begin
            n_next = n_avg_sum[CHUNK_W:1];
        end else begin
            n_next = cfg.normal;
        end
        if (n_next == '0) begin
            n_next = cfg.normal;
        end

        // saturate to the signed output range
        n_neg_wait = '0 - r_mag[CW-1:0];
        if (!r_neg) begin
            n_wait = (r_mag > NUM_W'(POS_MAX)) ? POS_MAX : r_mag[CW-1:0];
        end else begin
            n_wait = (r_mag > NUM_W'(NEG_MIN)) ? NEG_MIN : n_neg_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chunk   <= RST_NORMAL;
            r_start   <= 1'b0;
            r_pass    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (m_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_pass <= 1'b0;
                        if ((cfg.rate_limit == '0) || (in_step == '0)) begin
                            // throttling off: answer zero, leave the chunk alone
                            r_neg   <= 1'b0;
                            r_mag   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    r_sum   <= {1'b0, r_total} + SUM_W'(r_chunk);
                    r_start <= 1'b1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_neg   <= n_diff[DIFF_W-1];
                    r_mag   <= n_diff[DIFF_W-1] ? n_neg_diff[NUM_W-1:0]
                                                : n_diff[NUM_W-1:0];
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (!r_pass && (r_total > CW'(r_chunk))) begin
                        r_chunk <= n_next;
                        // a chunk off its default gets the wait recomputed
                        if (r_chunk != cfg.normal) begin
                            r_pass  <= 1'b1;
                            r_state <= S_SUM;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the result register is free
                    if (m_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_total   <= in_total;
            r_elapsed <= n_now - in_start;
        end
        if (m_load) begin
            r_m_data <= n_wait;
        end
    end

    a_disabled_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && ((cfg.rate_limit == '0) || (in_step == '0)))
            |=> (r_state == S_OUT))
        else $error("disabled throttle did not go straight to output");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divide finished outside the divide state");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !$past(r_m_valid)) |-> $past(r_state == S_OUT))
        else $error("result presented without passing the output state");

    a_single_recompute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_pass) |=> (r_state == S_OUT))
        else $error("wait recomputed more than once");

endmodule
